FILE: src/slrg_pkg.sv
`timescale 1ns / 1ps
package slrg_pkg;

  // Lehmer generator constants.
  localparam logic [14:0] LEHMER_MUL = 15'd16807;
  localparam logic [30:0] LEHMER_MOD = 31'h7FFF_FFFF;

  // Largest fraction code, kept just below one.
  localparam logic [23:0] FRAC_MAX = 24'd16777214;

  localparam int DEF_TABLE_DEPTH  = 32;
  localparam int DEF_WARMUP_STEPS = 8;

  // Configuration space.
  localparam int  ADDR_W   = 3;
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } core_state_t;

  // Finished draw handed from the core to the output register.
  typedef struct packed {
    logic        vld;
    logic [30:0] sample;
    logic [23:0] fraction;
  } res_t;

endpackage

FILE: src/slrg_lehmer.sv
`timescale 1ns / 1ps
module slrg_lehmer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] x,
  output logic        y_vld,
  output logic [30:0] y
);

  logic        prod_vld_r;
  logic [45:0] prod_r;
  logic [31:0] fold;
  logic [30:0] red;
  logic        y_vld_r;
  logic [30:0] y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      y_vld_r    <= 1'b0;
    end else begin
      prod_vld_r <= start;
      y_vld_r    <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= {15'b0, x} * {31'b0, slrg_pkg::LEHMER_MUL};
    y_r    <= red;
  end

  // Since the modulus is 2^31-1, the high part folds back onto the low part;
  // one conditional subtract then finishes the reduction.
  always_comb begin
    fold = {1'b0, prod_r[30:0]} + {17'b0, prod_r[45:31]};
    if (fold >= {1'b0, slrg_pkg::LEHMER_MOD}) begin
      red = 31'(fold - {1'b0, slrg_pkg::LEHMER_MOD});
    end else begin
      red = fold[30:0];
    end
  end

  assign y_vld = y_vld_r;
  assign y     = y_r;

endmodule

FILE: src/slrg_core.sv
`timescale 1ns / 1ps
module slrg_core #(
  parameter int TABLE_DEPTH  = slrg_pkg::DEF_TABLE_DEPTH,
  parameter int WARMUP_STEPS = slrg_pkg::DEF_WARMUP_STEPS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            restart,
  input  logic [30:0]     seed,
  output slrg_pkg::res_t  res,
  input  logic            res_ack
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int STEP_W = $clog2(WARMUP_STEPS + TABLE_DEPTH + 1);
  localparam logic [31:0] BUCKET = 32'(1 + 32'h7FFF_FFFE / TABLE_DEPTH);
  localparam logic [STEP_W-1:0] WARM_CNT  = STEP_W'(WARMUP_STEPS);
  localparam logic [STEP_W-1:0] FILL_TOP  = STEP_W'(WARMUP_STEPS + TABLE_DEPTH - 1);
  localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(WARMUP_STEPS + TABLE_DEPTH);

  slrg_pkg::core_state_t state_r, state_nxt;

  logic [STEP_W-1:0] cnt_r;
  logic [STEP_W-1:0] last_idx_r;
  logic              init_r;
  logic              inited_r;
  logic [30:0]       gen_r;
  logic [30:0]       last_r;
  logic              rd_arm_r;
  logic [IDX_W-1:0]  j_r;
  logic [30:0]       sample_r;
  logic [23:0]       frac_r;

  logic [30:0] mem [TABLE_DEPTH];
  logic [30:0] rd_r;

  logic              accept;
  logic              need_init;
  logic [30:0]       seed_fix;
  logic              step_go;
  logic [30:0]       step_x;
  logic              y_vld;
  logic [30:0]       y;
  logic              rd_arm;
  logic [IDX_W-1:0]  j;
  logic              fill_we;
  logic              draw_done;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [23:0]       frac;

  slrg_lehmer u_lehmer (
    .clk   (clk),
    .rst_n (rst_n),
    .start (step_go),
    .x     (step_x),
    .y_vld (y_vld),
    .y     (y)
  );

  assign accept    = (state_r == slrg_pkg::ST_IDLE) && in_valid;
  assign need_init = !inited_r || restart || (last_r == 31'd0);
  assign seed_fix  = ((seed == 31'd0) || (seed == slrg_pkg::LEHMER_MOD)) ? 31'd1 : seed;

  // Bucket index of the last output: highest threshold that it reaches.
  always_comb begin
    j = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if ({1'b0, last_r} >= 32'(k) * BUCKET) begin
        j = IDX_W'(k);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slrg_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = slrg_pkg::ST_RUN;
        end
      end
      slrg_pkg::ST_RUN: begin
        if (y_vld && (cnt_r == last_idx_r)) begin
          state_nxt = slrg_pkg::ST_DONE;
        end
      end
      slrg_pkg::ST_DONE: begin
        if (res_ack) begin
          state_nxt = slrg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slrg_pkg::ST_IDLE;
    endcase
  end

  // Steps run back to back: a finishing step's value seeds the next one.
  always_comb begin
    step_go   = 1'b0;
    step_x    = gen_r;
    rd_arm    = 1'b0;
    fill_we   = 1'b0;
    draw_done = 1'b0;
    unique case (state_r)
      slrg_pkg::ST_IDLE: begin
        step_go = accept;
        step_x  = need_init ? seed_fix : gen_r;
        rd_arm  = accept && !need_init;
      end
      slrg_pkg::ST_RUN: begin
        step_go   = y_vld && (cnt_r != last_idx_r);
        step_x    = y;
        rd_arm    = y_vld && ((cnt_r + 1'b1) == last_idx_r);
        fill_we   = y_vld && init_r && (cnt_r >= WARM_CNT) && (cnt_r < last_idx_r);
        draw_done = y_vld && (cnt_r == last_idx_r);
      end
      slrg_pkg::ST_DONE: begin
        step_go = 1'b0;
      end
      default: step_go = 1'b0;
    endcase
  end

  assign mem_we   = fill_we || draw_done;
  assign mem_wa   = draw_done ? j_r : IDX_W'(FILL_TOP - cnt_r);
  assign frac     = (rd_r[30:7] > slrg_pkg::FRAC_MAX) ? slrg_pkg::FRAC_MAX : rd_r[30:7];
  assign in_stall = (state_r != slrg_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= slrg_pkg::ST_IDLE;
      inited_r <= 1'b0;
      last_r   <= 31'd0;
      gen_r    <= 31'd0;
      rd_arm_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_arm_r <= rd_arm;
      if (accept && need_init) begin
        inited_r <= 1'b1;
      end
      if (fill_we && (cnt_r == FILL_TOP)) begin
        last_r <= y;
      end else if (draw_done) begin
        last_r <= rd_r;
      end
      if (draw_done) begin
        gen_r <= y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r      <= '0;
      init_r     <= need_init;
      last_idx_r <= need_init ? INIT_LAST : '0;
    end else if (y_vld) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (rd_arm_r) begin
      j_r <= j;
    end
    if (draw_done) begin
      sample_r <= rd_r;
      frac_r   <= frac;
    end
  end

  // Shuffle table.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= y;
    end
    if (rd_arm_r) begin
      rd_r <= mem[j];
    end
  end

  assign res.vld      = (state_r == slrg_pkg::ST_DONE);
  assign res.sample   = sample_r;
  assign res.fraction = frac_r;

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_arm_r && mem_we))
    else $error("table read and write in the same cycle");

  a_draw_has_read: assert property (@(posedge clk) disable iff (!rst_n)
    draw_done |-> $past(rd_arm_r))
    else $error("draw finished without a table read one cycle earlier");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != slrg_pkg::ST_RUN) |-> !y_vld)
    else $error("generator step finished outside of a transaction");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slrg_pkg::ST_RUN) |-> (cnt_r <= last_idx_r))
    else $error("step count ran past the last step");

endmodule

FILE: src/shuffled_lehmer_random_generator.sv
`timescale 1ns / 1ps
// Shuffled Lehmer random generator: a Park-Miller generator behind a
// Bays-Durham shuffle table. Every transaction on the input channel
// (in_valid/in_stall, field in_restart) yields exactly one transaction on
// the output channel (out_valid/out_stall, fields out_sample, out_fraction).
// The seed register sits at byte address 0 of the APB-style port.
// An ordinary draw takes one generator step (a registered multiply, then a
// registered fold modulo 2^31-1) plus the table read; the result passes
// through the core's result register into the output register, and the next
// input is taken only once the previous result has moved on to that register.
// The first request after reset, or a request with in_restart set, reloads
// from the seed: WARMUP_STEPS warm-up steps and TABLE_DEPTH fill steps run
// through the same step unit ahead of the draw's own step.
// Reset clears the control state and sets the seed to 1; the table needs
// no clearing because the first request always refills it.
// A stalled result holds in the output register while the core finishes
// the next transaction; the core then waits until the register frees up.
module shuffled_lehmer_random_generator #(
  parameter int TABLE_DEPTH  = slrg_pkg::DEF_TABLE_DEPTH,
  parameter int WARMUP_STEPS = slrg_pkg::DEF_WARMUP_STEPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [30:0]                 out_sample,
  output logic [23:0]                 out_fraction,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [slrg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [30:0]    seed_r;
  slrg_pkg::res_t res;
  logic           res_ack;
  logic           out_valid_r;
  logic [30:0]    out_sample_r;
  logic [23:0]    out_fraction_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 31'd1;
    end else if (psel && penable && pwrite && (paddr[2] == slrg_pkg::REG_SEED)) begin
      seed_r <= pwdata[30:0];
    end
  end

  assign prdata = (paddr[2] == slrg_pkg::REG_SEED) ? {1'b0, seed_r} : 32'd0;

  slrg_core #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .restart  (in_restart),
    .seed     (seed_r),
    .res      (res),
    .res_ack  (res_ack)
  );

  assign res_ack = res.vld && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ack) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_sample_r   <= res.sample;
      out_fraction_r <= res.fraction;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_fraction = out_fraction_r;

endmodule

FILE: tb/shuffled_lehmer_random_generator_checker.sv
`timescale 1ns / 1ps
module shuffled_lehmer_random_generator_checker #(
  parameter int TABLE_DEPTH  = slrg_pkg::DEF_TABLE_DEPTH,
  parameter int WARMUP_STEPS = slrg_pkg::DEF_WARMUP_STEPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_restart,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [30:0]                 out_sample,
  input  logic [23:0]                 out_fraction,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [slrg_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int unsigned                 pending,
  output int unsigned                 fail_count
);

  // Width of one index bucket of the shuffle table.
  localparam longint unsigned BUCKET_DIV =
    1 + (longint'(slrg_pkg::LEHMER_MOD) - 1) / longint'(TABLE_DEPTH);

  typedef struct packed {
    logic [30:0] sample;
    logic [23:0] fraction;
  } draw_t;

  logic [30:0] seed_reg;
  logic [30:0] gen_value;
  logic [30:0] last_drawn;
  logic [30:0] shuffle_tbl [TABLE_DEPTH];
  logic        tbl_loaded;
  draw_t       expected_draws [$];

  function automatic logic [30:0] lehmer_advance(input logic [30:0] x);
    longint unsigned prod;
    prod = longint'(x) * longint'(slrg_pkg::LEHMER_MUL);
    return 31'(prod % longint'(slrg_pkg::LEHMER_MOD));
  endfunction

  function automatic void reload_shuffle_table();
    logic [30:0] x;
    x = seed_reg;
    // A zero or modulus seed would lock the generator at zero.
    if (x == 31'd0 || x == slrg_pkg::LEHMER_MOD) x = 31'd1;
    for (int i = 0; i < WARMUP_STEPS; i++) x = lehmer_advance(x);
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      x = lehmer_advance(x);
      shuffle_tbl[i] = x;
    end
    gen_value  = x;
    last_drawn = shuffle_tbl[0];
    tbl_loaded = 1'b1;
  endfunction

  function automatic draw_t predict_draw(input logic restart);
    draw_t           d;
    longint unsigned slot;
    longint unsigned frac;
    if (!tbl_loaded || restart || last_drawn == 31'd0) reload_shuffle_table();
    gen_value = lehmer_advance(gen_value);
    slot = longint'(last_drawn) / BUCKET_DIV;
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    last_drawn = shuffle_tbl[slot];
    shuffle_tbl[slot] = gen_value;
    frac = (longint'(last_drawn) << 24) / longint'(slrg_pkg::LEHMER_MOD);
    if (frac > longint'(slrg_pkg::FRAC_MAX)) frac = longint'(slrg_pkg::FRAC_MAX);
    d.sample   = last_drawn;
    d.fraction = 24'(frac);
    return d;
  endfunction

  task automatic note_mismatch(input string what, input longint unsigned exp_v,
                               input longint unsigned act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    draw_t want;
    if (!rst_n) begin
      seed_reg   = 31'd1;
      gen_value  = 31'd0;
      last_drawn = 31'd0;
      tbl_loaded = 1'b0;
      expected_draws.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == slrg_pkg::REG_SEED)
        seed_reg = pwdata[30:0];
      if (in_valid && !in_stall)
        expected_draws.push_back(predict_draw(in_restart));
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          note_mismatch("unexpected output transaction, sample", 0, out_sample);
        end else begin
          want = expected_draws.pop_front();
          if (out_sample !== want.sample)
            note_mismatch("sample", want.sample, out_sample);
          if (out_fraction !== want.fraction)
            note_mismatch("fraction", want.fraction, out_fraction);
        end
      end
    end
    pending <= expected_draws.size();
  end

endmodule

FILE: tb/shuffled_lehmer_random_generator_tb.sv
`timescale 1ns / 1ps
module shuffled_lehmer_random_generator_tb;

  localparam logic [slrg_pkg::ADDR_W-1:0] SEED_ADDR  =
    slrg_pkg::ADDR_W'(4 * slrg_pkg::REG_SEED);
  localparam logic [slrg_pkg::ADDR_W-1:0] OTHER_ADDR = SEED_ADDR + slrg_pkg::ADDR_W'(4);
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 241;
  localparam int HOLD_CYCLES      = 300;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_restart;
  logic                        out_valid;
  logic                        out_stall;
  logic [30:0]                 out_sample;
  logic [23:0]                 out_fraction;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [slrg_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  int unsigned                 pending;
  int unsigned                 fail_count;
  bit                          hold_request;

  shuffled_lehmer_random_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_restart  (in_restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .out_fraction(out_fraction),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  shuffled_lehmer_random_generator_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_restart  (in_restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .out_fraction(out_fraction),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("shuffled_lehmer_random_generator_tb: done, errors");
    $finish;
  end

  // Receiver: stalls in segments of changing character, plus one long hold-off.
  initial begin
    int seg_len;
    int mode;
    out_stall = 1'b0;
    forever begin
      seg_len = $urandom_range(1, 60);
      mode    = $urandom_range(0, 3);
      for (int k = 0; k < seg_len; k++) begin
        @(posedge clk);
        if (hold_request) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_request = 1'b0;
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (k % 4 < 2);
        endcase
      end
    end
  end

  // Offers one request and holds it until the block takes it. A zero gap keeps
  // in_valid high so the next request follows back to back.
  task automatic send_request(input logic restart, input int gap);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid   <= 1'b0;
      in_restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [slrg_pkg::ADDR_W-1:0] addr,
                           input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_seed_phase(input logic [31:0] seed_word);
    wait_drained();
    write_reg(SEED_ADDR, seed_word);
    send_request(1'b1, 0);
    send_request(1'b0, 0);
    send_request(1'b0, 1);
  endtask

  initial begin
    logic [31:0] seed_word;
    int          burst_left;
    int          gap;
    in_valid     = 1'b0;
    in_restart   = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first request loads from the reset seed even without restart.
    send_request(1'b0, 0);
    send_request(1'b0, 0);
    send_request(1'b0, 0);
    send_request(1'b1, 0);
    send_request(1'b0, 0);
    send_request(1'b0, 1);

    // Zero and the modulus both fall back to a seed of one.
    run_seed_phase(32'h0000_0000);
    run_seed_phase(32'h7FFF_FFFF);
    run_seed_phase(32'h7FFF_FFFE);
    run_seed_phase(32'hFFFF_FFFF);
    run_seed_phase(32'h8000_0001);

    // A write outside the seed register must leave the seed alone.
    wait_drained();
    write_reg(SEED_ADDR, 32'd12345);
    write_reg(OTHER_ADDR, 32'h5A5A_A5A5);
    send_request(1'b1, 0);
    send_request(1'b0, 1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0: seed_word = 32'd1;
        1: seed_word = 32'h7FFF_FFFE;
        2: seed_word = 32'($urandom_range(1, 2147483646));
        default: seed_word = $urandom();
      endcase
      write_reg(SEED_ADDR, seed_word);
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == 5) hold_request = 1'b1;
        if (burst_left == 0)
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        burst_left--;
        if (n == ITEMS_PER_PHASE - 1) gap = 1;
        else if (burst_left == 0) gap = $urandom_range(1, 12);
        else gap = 0;
        send_request(($urandom_range(0, 15) == 0), gap);
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("shuffled_lehmer_random_generator_tb: done, clean");
    end else begin
      $display("shuffled_lehmer_random_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
